>>> hw/rtl/i2cdw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the i2c display write framer
// no dependencies
package i2cdw_pkg;

  // bus phase codes
  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_ST0      = 5'd1;
  localparam logic [4:0] PH_ST1      = 5'd2;
  localparam logic [4:0] PH_ST2      = 5'd3;
  localparam logic [4:0] PH_BIT_LO   = 5'd4;
  localparam logic [4:0] PH_BIT_HI   = 5'd5;
  localparam logic [4:0] PH_BIT_TAIL = 5'd6;
  localparam logic [4:0] PH_ACK_LO   = 5'd7;
  localparam logic [4:0] PH_ACK_HI   = 5'd8;
  localparam logic [4:0] PH_ACK_TAIL = 5'd9;
  localparam logic [4:0] PH_STOP     = 5'd10;

  // request opcodes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_CMD_WRITE = 2'd1;
  localparam logic [1:0] OP_DAT_WRITE = 2'd2;

  // control bytes
  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  // configuration register indexes and reset values
  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_SEG_TICKS = 1'b1;
  localparam logic [7:0] DEV_ADDR_RST = 8'd120;
  localparam logic [9:0] SEG_TICKS_RST = 10'd10;

  localparam logic [3:0] LAST_BIT = 4'd7;

  // one result item, scl in the lowest bit
  typedef struct packed {
    logic done;
    logic nack;
    logic busy;
    logic sda;
    logic scl;
  } res_t;

endpackage

>>> hw/rtl/i2c_display_write_framer.sv
`timescale 1ns / 1ps
// i2c display write framer top level: config registers, sequencer, result buffer
// depends on i2cdw_pkg, i2cdw_core and i2cdw_skid
//
// Each input item is one tick of bus timing; every item produces exactly one result
// item holding the scl/sda levels after that tick, busy, the sticky nack flag and a
// one-tick done pulse at the end of the stop condition. A tick with opcode 1 (command)
// or 2 (data) while idle starts a transaction: start, device address byte, control
// byte (0x00 command, 0x40 data), payload byte, each msb first with an ack clock,
// then stop; every line segment lasts segment_ticks ticks (0 acts as 1). Requests
// while busy are ignored. Throughput is one item per clock while the skid entry is
// empty: the whole per-tick update of the sequencer state is combinational into its
// registers, and a result register plus one skid entry let a new item be taken while an
// earlier result waits. Registers: device_address at 0x0, segment_ticks at 0x4, to be
// written by the user only while no item is in flight; the block does not enforce it.
module i2c_display_write_framer (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] tx_byte, [8] sda_in, [15:9] zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] scl_out, [1] sda_out, [2] busy_res,
                                  // [3] nack_seen, [4] done_res, [7:5] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]      dev_addr_r;
  logic [9:0]      seg_ticks_r;
  logic            in_acc;
  logic            cfg_wr;
  i2cdw_pkg::res_t core_res;
  i2cdw_pkg::res_t out_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register index is address bit 2; other address bits are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= i2cdw_pkg::DEV_ADDR_RST;
      seg_ticks_r <= i2cdw_pkg::SEG_TICKS_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == i2cdw_pkg::REG_DEV_ADDR) begin
        dev_addr_r <= cfg_pwdata[7:0];
      end else begin
        seg_ticks_r <= cfg_pwdata[9:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      i2cdw_pkg::REG_DEV_ADDR:  cfg_prdata = {24'd0, dev_addr_r};
      i2cdw_pkg::REG_SEG_TICKS: cfg_prdata = {22'd0, seg_ticks_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  // sequencer state moves only on an accepted tick
  assign in_acc = in_tvalid && in_tready;

  i2cdw_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .opcode    (in_tuser),
    .tx_byte   (in_tdata[7:0]),
    .sda_in    (in_tdata[8]),
    .dev_addr  (dev_addr_r),
    .seg_ticks (seg_ticks_r),
    .res       (core_res)
  );

  // result register and skid entry decouple the two sides
  i2cdw_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_acc),
    .wr_ready (in_tready),
    .wr_data  (core_res),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (out_res)
  );

  assign out_tdata = {3'd0, out_res};

endmodule

>>> hw/rtl/i2cdw_core.sv
`timescale 1ns / 1ps
// bus sequencer: state registers and per-tick next-state logic
// depends on i2cdw_pkg
module i2cdw_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [1:0]         opcode,
  input  logic [7:0]         tx_byte,
  input  logic               sda_in,
  input  logic [7:0]         dev_addr,
  input  logic [9:0]         seg_ticks,
  output i2cdw_pkg::res_t    res
);

  logic [4:0] phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [1:0] byte_pos_r, byte_pos_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] payload_r, payload_nxt;
  logic       dsel_r, dsel_nxt;
  logic [9:0] tick_r, tick_nxt;
  logic       nack_r, nack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       done;
  logic [9:0] seg;
  logic [9:0] tick_inc;

  assign seg      = (seg_ticks == 10'd0) ? 10'd1 : seg_ticks;
  assign tick_inc = tick_r + 10'd1;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_pos_nxt = byte_pos_r;
    shift_nxt    = shift_r;
    payload_nxt  = payload_r;
    dsel_nxt     = dsel_r;
    tick_nxt     = tick_r;
    nack_nxt     = nack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    done         = 1'b0;
    if (acc) begin
      if (phase_r == i2cdw_pkg::PH_IDLE) begin
        if (opcode == i2cdw_pkg::OP_CMD_WRITE || opcode == i2cdw_pkg::OP_DAT_WRITE) begin
          payload_nxt  = tx_byte;
          dsel_nxt     = (opcode == i2cdw_pkg::OP_DAT_WRITE);
          nack_nxt     = 1'b0;
          bit_cnt_nxt  = 4'd0;
          byte_pos_nxt = 2'd0;
          shift_nxt    = 8'd0;
          tick_nxt     = 10'd0;
          phase_nxt    = i2cdw_pkg::PH_ST0;
          scl_nxt      = 1'b1;
          sda_nxt      = 1'b1;
        end
      end else begin
        tick_nxt = tick_inc;
        if (tick_inc >= seg) begin
          tick_nxt = 10'd0;
          case (phase_r)
            i2cdw_pkg::PH_ST0: begin
              phase_nxt = i2cdw_pkg::PH_ST1;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b0;
            end
            i2cdw_pkg::PH_ST1: begin
              phase_nxt = i2cdw_pkg::PH_ST2;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
            end
            i2cdw_pkg::PH_ST2: begin
              byte_pos_nxt = 2'd0;
              shift_nxt    = dev_addr;
              bit_cnt_nxt  = 4'd0;
              phase_nxt    = i2cdw_pkg::PH_BIT_LO;
              scl_nxt      = 1'b0;
              sda_nxt      = dev_addr[7];
            end
            i2cdw_pkg::PH_BIT_LO: begin
              phase_nxt = i2cdw_pkg::PH_BIT_HI;
              scl_nxt   = 1'b1;
              sda_nxt   = shift_r[7];
            end
            i2cdw_pkg::PH_BIT_HI: begin
              phase_nxt = i2cdw_pkg::PH_BIT_TAIL;
              scl_nxt   = 1'b0;
              // release the data line after the eighth bit
              sda_nxt   = (bit_cnt_r >= i2cdw_pkg::LAST_BIT) ? 1'b1 : shift_r[7];
            end
            i2cdw_pkg::PH_BIT_TAIL: begin
              shift_nxt = {shift_r[6:0], 1'b0};
              scl_nxt   = 1'b0;
              if (bit_cnt_r >= i2cdw_pkg::LAST_BIT) begin
                bit_cnt_nxt = 4'd0;
                phase_nxt   = i2cdw_pkg::PH_ACK_LO;
                sda_nxt     = 1'b1;
              end else begin
                bit_cnt_nxt = bit_cnt_r + 4'd1;
                phase_nxt   = i2cdw_pkg::PH_BIT_LO;
                sda_nxt     = shift_r[6];
              end
            end
            i2cdw_pkg::PH_ACK_LO: begin
              phase_nxt = i2cdw_pkg::PH_ACK_HI;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end
            i2cdw_pkg::PH_ACK_HI: begin
              if (sda_in) begin
                nack_nxt = 1'b1;
              end
              phase_nxt = i2cdw_pkg::PH_ACK_TAIL;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
            end
            i2cdw_pkg::PH_ACK_TAIL: begin
              if (byte_pos_r >= 2'd2) begin
                phase_nxt = i2cdw_pkg::PH_STOP;
                scl_nxt   = 1'b1;
                sda_nxt   = 1'b0;
              end else if (byte_pos_r == 2'd0) begin
                byte_pos_nxt = 2'd1;
                shift_nxt    = dsel_r ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_COMMAND;
                bit_cnt_nxt  = 4'd0;
                phase_nxt    = i2cdw_pkg::PH_BIT_LO;
                scl_nxt      = 1'b0;
                sda_nxt      = dsel_r ? i2cdw_pkg::CTRL_DATA[7] : i2cdw_pkg::CTRL_COMMAND[7];
              end else begin
                byte_pos_nxt = 2'd2;
                shift_nxt    = payload_r;
                bit_cnt_nxt  = 4'd0;
                phase_nxt    = i2cdw_pkg::PH_BIT_LO;
                scl_nxt      = 1'b0;
                sda_nxt      = payload_r[7];
              end
            end
            i2cdw_pkg::PH_STOP: begin
              phase_nxt    = i2cdw_pkg::PH_IDLE;
              byte_pos_nxt = 2'd0;
              bit_cnt_nxt  = 4'd0;
              scl_nxt      = 1'b1;
              sda_nxt      = 1'b1;
              done         = 1'b1;
            end
            default: begin
              phase_nxt = i2cdw_pkg::PH_IDLE;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= i2cdw_pkg::PH_IDLE;
      bit_cnt_r  <= 4'd0;
      byte_pos_r <= 2'd0;
      shift_r    <= 8'd0;
      payload_r  <= 8'd0;
      dsel_r     <= 1'b0;
      tick_r     <= 10'd0;
      nack_r     <= 1'b0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
    end else begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_pos_r <= byte_pos_nxt;
      shift_r    <= shift_nxt;
      payload_r  <= payload_nxt;
      dsel_r     <= dsel_nxt;
      tick_r     <= tick_nxt;
      nack_r     <= nack_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
    end
  end

  // result reflects the levels after this tick's update
  assign res.scl  = scl_nxt;
  assign res.sda  = sda_nxt;
  assign res.busy = (phase_nxt != i2cdw_pkg::PH_IDLE);
  assign res.nack = nack_nxt;
  assign res.done = done;

`ifndef SYNTH
  a_start_enters_st0: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == i2cdw_pkg::PH_IDLE &&
     (opcode == i2cdw_pkg::OP_CMD_WRITE || opcode == i2cdw_pkg::OP_DAT_WRITE))
    |=> (phase_r == i2cdw_pkg::PH_ST0 && tick_r == 10'd0 && !nack_r))
    else $error("request from idle did not open a start condition");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2cdw_pkg::PH_IDLE) |-> (scl_r && sda_r))
    else $error("bus lines not released while idle");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2cdw_pkg::PH_BIT_LO || phase_r == i2cdw_pkg::PH_BIT_HI ||
     phase_r == i2cdw_pkg::PH_BIT_TAIL) |-> (bit_cnt_r <= i2cdw_pkg::LAST_BIT))
    else $error("bit counter beyond last bit");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (phase_r == i2cdw_pkg::PH_IDLE))
    else $error("stop completed but sequencer not idle");
`endif

endmodule

>>> hw/rtl/i2cdw_skid.sv
`timescale 1ns / 1ps
// result register with one skid entry behind it
// depends on i2cdw_pkg
module i2cdw_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  i2cdw_pkg::res_t  wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output i2cdw_pkg::res_t  rd_data
);

  logic            out_vld_r;
  logic            skid_vld_r;
  i2cdw_pkg::res_t out_r;
  i2cdw_pkg::res_t skid_r;

  assign wr_ready = !skid_vld_r;
  assign rd_valid = out_vld_r;
  assign rd_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || rd_ready) begin
      out_vld_r  <= skid_vld_r || wr_valid;
      skid_vld_r <= 1'b0;
    end else if (wr_valid && !skid_vld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || rd_ready) begin
      out_r <= skid_vld_r ? skid_r : wr_data;
    end else if (wr_valid && !skid_vld_r) begin
      skid_r <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !rd_ready) |=> out_vld_r)
    else $error("pending item dropped");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && rd_ready) |=> (out_vld_r && !skid_vld_r))
    else $error("skid entry not moved forward");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the i2c display write framer
// depends on i2cdw_pkg and i2c_display_write_framer
module tb;

  // unused opcode value, must act as a plain tick
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // byte positions inside one write
  localparam logic [1:0] POS_ADDR    = 2'd0;
  localparam logic [1:0] POS_CTRL    = 2'd1;
  localparam logic [1:0] POS_PAYLOAD = 2'd2;

  // how the bench drives sda_in during a write
  localparam int ACK_LOW   = 0;
  localparam int ACK_HIGH  = 1;
  localparam int ACK_MIXED = 2;

  // random traffic runs until this many items have been sent in total
  localparam int ITEMS_TARGET = 650;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] tx_byte, [8] sda_in, [15:9] zero
  logic [1:0]  in_tuser;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] scl, [1] sda, [2] busy, [3] nack, [4] done, [7:5] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  i2c_display_write_framer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // bench control and bookkeeping
  // ---------------------------------------------------------------------------
  bit   fast_mode;        // no random waits on either side while set
  int   hold_left;        // long receiver hold-off, counted down at falling edges
  int   stall_left;       // receiver wait before the next result item
  int   items_sent;
  int   n_checked;
  int   n_errors;
  int   n_done;
  int   n_done_nack;
  i2cdw_pkg::res_t expected_levels[$];

  // ---------------------------------------------------------------------------
  // predictor: bus sequencer state and its copy of the registers
  // ---------------------------------------------------------------------------
  logic [7:0] cfg_dev_addr;
  logic [9:0] cfg_seg_ticks;
  logic [4:0] ph;
  logic [3:0] bit_cnt;
  logic [1:0] byte_pos;
  logic [7:0] shreg;
  logic [7:0] payload;
  logic       is_data;
  logic [9:0] seg_cnt;
  logic       nack_m;
  logic       scl_m;
  logic       sda_m;

  // start shifting a new byte, first bit goes out with scl low
  function automatic void load_shift(input logic [7:0] value);
    shreg   = value;
    bit_cnt = '0;
    ph      = i2cdw_pkg::PH_BIT_LO;
    scl_m   = 1'b0;
    sda_m   = value[7];
  endfunction

  // end of the current line segment; returns 1 when the stop condition completes
  function automatic logic end_segment(input logic sda_s);
    logic stop_done;
    stop_done = 1'b0;
    case (ph)
      i2cdw_pkg::PH_ST0: begin
        ph = i2cdw_pkg::PH_ST1; scl_m = 1'b1; sda_m = 1'b0;
      end
      i2cdw_pkg::PH_ST1: begin
        ph = i2cdw_pkg::PH_ST2; scl_m = 1'b0; sda_m = 1'b0;
      end
      i2cdw_pkg::PH_ST2: begin
        byte_pos = POS_ADDR;
        load_shift(cfg_dev_addr);
      end
      i2cdw_pkg::PH_BIT_LO: begin
        ph = i2cdw_pkg::PH_BIT_HI; scl_m = 1'b1; sda_m = shreg[7];
      end
      i2cdw_pkg::PH_BIT_HI: begin
        // after the eighth bit the line is released for the ack
        ph = i2cdw_pkg::PH_BIT_TAIL; scl_m = 1'b0;
        sda_m = (bit_cnt >= i2cdw_pkg::LAST_BIT) ? 1'b1 : shreg[7];
      end
      i2cdw_pkg::PH_BIT_TAIL: begin
        shreg = shreg << 1;
        if (bit_cnt >= i2cdw_pkg::LAST_BIT) begin
          bit_cnt = '0; ph = i2cdw_pkg::PH_ACK_LO; scl_m = 1'b0; sda_m = 1'b1;
        end else begin
          bit_cnt = bit_cnt + 4'd1; ph = i2cdw_pkg::PH_BIT_LO;
          scl_m = 1'b0; sda_m = shreg[7];
        end
      end
      i2cdw_pkg::PH_ACK_LO: begin
        ph = i2cdw_pkg::PH_ACK_HI; scl_m = 1'b1; sda_m = 1'b1;
      end
      i2cdw_pkg::PH_ACK_HI: begin
        // sda sampled on the last tick of the high ack segment, sticky
        if (sda_s) nack_m = 1'b1;
        ph = i2cdw_pkg::PH_ACK_TAIL; scl_m = 1'b0; sda_m = 1'b1;
      end
      i2cdw_pkg::PH_ACK_TAIL: begin
        if (byte_pos >= POS_PAYLOAD) begin
          ph = i2cdw_pkg::PH_STOP; scl_m = 1'b1; sda_m = 1'b0;
        end else if (byte_pos == POS_ADDR) begin
          byte_pos = POS_CTRL;
          load_shift(is_data ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_COMMAND);
        end else begin
          byte_pos = POS_PAYLOAD;
          load_shift(payload);
        end
      end
      i2cdw_pkg::PH_STOP: begin
        ph = i2cdw_pkg::PH_IDLE; byte_pos = POS_ADDR; bit_cnt = '0;
        scl_m = 1'b1; sda_m = 1'b1;
        stop_done = 1'b1;
      end
      default: begin
        ph = i2cdw_pkg::PH_IDLE; scl_m = 1'b1; sda_m = 1'b1;
      end
    endcase
    return stop_done;
  endfunction

  // one tick of the sequencer, returns the levels that tick must show
  function automatic i2cdw_pkg::res_t step_bus(input logic [1:0] op, input logic [7:0] b,
                                               input logic sda_s);
    i2cdw_pkg::res_t r;
    logic [9:0]      seg_len;
    logic            stop_done;
    seg_len   = (cfg_seg_ticks == '0) ? 10'd1 : cfg_seg_ticks;
    stop_done = 1'b0;
    if (ph == i2cdw_pkg::PH_IDLE) begin
      if (op == i2cdw_pkg::OP_CMD_WRITE || op == i2cdw_pkg::OP_DAT_WRITE) begin
        payload  = b;
        is_data  = (op == i2cdw_pkg::OP_DAT_WRITE);
        nack_m   = 1'b0;
        bit_cnt  = '0;
        byte_pos = POS_ADDR;
        shreg    = '0;
        seg_cnt  = '0;
        ph       = i2cdw_pkg::PH_ST0;
        scl_m    = 1'b1;
        sda_m    = 1'b1;
      end
    end else begin
      // requests while busy fall through here and are ignored
      seg_cnt = seg_cnt + 10'd1;
      if (seg_cnt >= seg_len) begin
        seg_cnt   = '0;
        stop_done = end_segment(sda_s);
      end
    end
    r.scl  = scl_m;
    r.sda  = sda_m;
    r.busy = (ph != i2cdw_pkg::PH_IDLE);
    r.nack = nack_m;
    r.done = stop_done;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and the time limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("timeout at %0t with %0d result items outstanding", $time,
             expected_levels.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: ready with random waits, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_tready <= rst_n;
      end
    end
  end

  function automatic void check_field(input string name, input logic e, input logic a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %b, got %b", $time, name, e, a);
      n_errors++;
    end
  endfunction

  // compare every accepted result item against the oldest expectation
  always @(posedge clk) begin
    i2cdw_pkg::res_t exp_r;
    i2cdw_pkg::res_t got_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_r = i2cdw_pkg::res_t'(out_tdata[4:0]);
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got %h", $time, out_tdata);
        n_errors++;
      end else begin
        exp_r = expected_levels.pop_front();
        check_field("scl_out", exp_r.scl, got_r.scl);
        check_field("sda_out", exp_r.sda, got_r.sda);
        check_field("busy_res", exp_r.busy, got_r.busy);
        check_field("nack_seen", exp_r.nack, got_r.nack);
        check_field("done_res", exp_r.done, got_r.done);
        if (out_tdata[7:5] !== 3'b000) begin
          $display("%0t: pad bits mismatch, expected 000, got %b", $time, out_tdata[7:5]);
          n_errors++;
        end
        n_checked++;
        if (got_r.done === 1'b1) begin
          n_done++;
          if (got_r.nack === 1'b1) n_done_nack++;
        end
      end
      stall_left = fast_mode ? 0 : $urandom_range(0, 14);
    end
  end

  // ---------------------------------------------------------------------------
  // input side: one tick item per call, predicted at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [1:0] op, input logic [7:0] b, input logic sda_s);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, sda_s, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_levels.push_back(step_bus(op, b, sda_s));
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering items and let every outstanding result come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // register write followed by a read-back of the same register
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] stored;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == i2cdw_pkg::REG_DEV_ADDR) cfg_dev_addr = value[7:0];
    else                                cfg_seg_ticks = value[9:0];
    stored = (idx == i2cdw_pkg::REG_DEV_ADDR) ? {24'b0, cfg_dev_addr}
                                              : {22'b0, cfg_seg_ticks};
    @(negedge clk);
    // read setup cycle, psel stays high
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== stored) begin
      $display("%0t: read-back of register %0d mismatch, expected %h, got %h",
               $time, idx, stored, cfg_prdata);
      n_errors++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // one full write, with random opcodes offered while busy; cut_at > 0 rewrites
  // segment_ticks after cut_at - 1 busy ticks
  task automatic run_write(input logic [1:0] op, input logic [7:0] b, input int ack_mode,
                           input int cut_at, input logic [9:0] later_seg);
    int   n;
    logic sda_s;
    n = 0;
    send_tick(op, b, 1'b0);
    while (ph != i2cdw_pkg::PH_IDLE) begin
      n++;
      if (n == cut_at) begin
        drain();
        write_reg(i2cdw_pkg::REG_SEG_TICKS, {22'b0, later_seg});
      end
      if (ack_mode == ACK_HIGH)       sda_s = 1'b1;
      else if (ack_mode == ACK_MIXED) sda_s = ($urandom_range(0, 3) == 0);
      else                            sda_s = 1'b0;
      send_tick(2'($urandom_range(0, 3)), 8'($urandom), sda_s);
    end
  endtask

  function automatic logic [9:0] pick_seg_len();
    case ($urandom_range(0, 9))
      6, 7:    return 10'd2;
      8:       return 10'd0;
      9:       return 10'd3;
      default: return 10'd1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // idle ticks: plain and unused opcodes, byte and sda extremes, nothing starts
  task automatic test_idle_ticks();
    send_tick(i2cdw_pkg::OP_TICK, 8'h00, 1'b0);
    send_tick(i2cdw_pkg::OP_TICK, 8'hff, 1'b1);
    send_tick(OP_UNUSED, 8'h00, 1'b1);
    send_tick(OP_UNUSED, 8'hff, 1'b0);
  endtask

  // first write opens on the reset register values, then the length is cut to one
  // while the running count already reaches it
  task automatic test_reset_settings();
    run_write(i2cdw_pkg::OP_CMD_WRITE, 8'h3c, ACK_LOW, 12, 10'd1);
  endtask

  // command writes at the byte extremes and a data write, nack set, held, then cleared
  task automatic test_write_extremes();
    drain();
    write_reg(i2cdw_pkg::REG_DEV_ADDR, 32'h0000_00ff);
    write_reg(i2cdw_pkg::REG_SEG_TICKS, 32'd1);
    run_write(i2cdw_pkg::OP_CMD_WRITE, 8'h00, ACK_LOW, 0, 10'd0);
    run_write(i2cdw_pkg::OP_CMD_WRITE, 8'hff, ACK_HIGH, 0, 10'd0);
    // nack_seen must hold while idle
    send_tick(i2cdw_pkg::OP_TICK, 8'h55, 1'b0);
    send_tick(OP_UNUSED, 8'haa, 1'b1);
    // a new request clears it again
    run_write(i2cdw_pkg::OP_DAT_WRITE, 8'h80, ACK_LOW, 0, 10'd0);
  endtask

  // zero segment length acts as one tick
  task automatic test_zero_segment();
    drain();
    write_reg(i2cdw_pkg::REG_DEV_ADDR, 32'h0000_0000);
    write_reg(i2cdw_pkg::REG_SEG_TICKS, 32'd0);
    run_write(i2cdw_pkg::OP_DAT_WRITE, 8'hff, ACK_MIXED, 0, 10'd0);
  endtask

  // longest segment length, then a shorter length is written mid-segment
  // while the running count already exceeds it
  task automatic test_long_segment();
    drain();
    write_reg(i2cdw_pkg::REG_DEV_ADDR, {24'b0, 8'($urandom)});
    write_reg(i2cdw_pkg::REG_SEG_TICKS, 32'd1023);
    fast_mode = 1'b1;
    run_write(i2cdw_pkg::OP_CMD_WRITE, 8'ha5, ACK_LOW, 20, 10'd1);
    fast_mode = 1'b0;
  endtask

  // receiver holds off for a long stretch while ticks keep coming
  task automatic test_backpressure();
    drain();
    write_reg(i2cdw_pkg::REG_SEG_TICKS, 32'd1);
    fast_mode = 1'b1;
    hold_left = 300;
    run_write(i2cdw_pkg::OP_DAT_WRITE, 8'($urandom), ACK_MIXED, 0, 10'd0);
    fast_mode = 1'b0;
  endtask

  // random writes with random settings, noise ticks and mid-write length changes
  task automatic test_random_traffic();
    int         ack_mode;
    int         cut_at;
    logic [1:0] op;
    do begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0:       write_reg(i2cdw_pkg::REG_DEV_ADDR, 32'h0000_0000);
          1:       write_reg(i2cdw_pkg::REG_DEV_ADDR, 32'h0000_00ff);
          default: write_reg(i2cdw_pkg::REG_DEV_ADDR, {24'b0, 8'($urandom)});
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        drain();
        write_reg(i2cdw_pkg::REG_SEG_TICKS, {22'b0, pick_seg_len()});
      end
      fast_mode = ($urandom_range(0, 3) == 0);
      // noise between writes
      repeat ($urandom_range(0, 4)) begin
        op = ($urandom_range(0, 1) == 0) ? i2cdw_pkg::OP_TICK : OP_UNUSED;
        send_tick(op, 8'($urandom), 1'($urandom));
      end
      ack_mode = $urandom_range(0, 5);
      if (ack_mode > ACK_MIXED) ack_mode = ACK_LOW;
      cut_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
      op = ($urandom_range(0, 1) == 0) ? i2cdw_pkg::OP_CMD_WRITE : i2cdw_pkg::OP_DAT_WRITE;
      run_write(op, 8'($urandom), ack_mode, cut_at, pick_seg_len());
    end while (items_sent < ITEMS_TARGET);
    fast_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = i2cdw_pkg::OP_TICK;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    fast_mode   = 1'b0;
    hold_left   = 0;
    stall_left  = 0;
    items_sent  = 0;
    n_checked   = 0;
    n_errors    = 0;
    n_done      = 0;
    n_done_nack = 0;

    // predictor reset state
    cfg_dev_addr  = i2cdw_pkg::DEV_ADDR_RST;
    cfg_seg_ticks = i2cdw_pkg::SEG_TICKS_RST;
    ph       = i2cdw_pkg::PH_IDLE;
    bit_cnt  = '0;
    byte_pos = POS_ADDR;
    shreg    = '0;
    payload  = '0;
    is_data  = 1'b0;
    seg_cnt  = '0;
    nack_m   = 1'b0;
    scl_m    = 1'b1;
    sda_m    = 1'b1;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_idle_ticks();
    test_reset_settings();
    test_write_extremes();
    test_zero_segment();
    test_long_segment();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (10) @(negedge clk);
    $display("checked %0d tick results over %0d writes (%0d ended with nack)",
             n_checked, n_done, n_done_nack);
    $display("segment lengths 0 to 1023, addresses 0x00 to 0xff, mid-write length changes");
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
